// ----- hw/rtl/mprb_pkg.sv -----
package mprb_pkg;

  // Pool geometry. BUF_BYTES is a power of two so pointers wrap by overflow.
  localparam int NUM_PIPES      = 16;
  localparam int BUF_BYTES      = 512;
  localparam int MAX_READ_BURST = 64;

  localparam int PIPE_W      = $clog2(NUM_PIPES);
  localparam int PTR_W       = $clog2(BUF_BYTES);
  localparam int STORE_DEPTH = NUM_PIPES * BUF_BYTES;
  localparam int CNT_W       = 7;

  // Request codes
  localparam logic [2:0] REQ_ALLOC   = 3'd0;
  localparam logic [2:0] REQ_WRITE   = 3'd1;
  localparam logic [2:0] REQ_READ    = 3'd2;
  localparam logic [2:0] REQ_CLOSE_R = 3'd3;
  localparam logic [2:0] REQ_CLOSE_W = 3'd4;

  // Status codes
  localparam logic [2:0] STS_OK     = 3'd0;
  localparam logic [2:0] STS_BAD    = 3'd1;
  localparam logic [2:0] STS_BROKEN = 3'd2;
  localparam logic [2:0] STS_FULL   = 3'd3;
  localparam logic [2:0] STS_EMPTY  = 3'd4;
  localparam logic [2:0] STS_EOF    = 3'd5;
  localparam logic [2:0] STS_NOFREE = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_BURST  = 3'b100
  } state_t;

endpackage

// ----- hw/rtl/multi_pipe_ring_buffer_pool_unit.sv -----
// Sequencing: a request is captured and its pipe's pointers read on accept;
//   when the output is free, S_LOOKUP loads allocate, write, close and
//   non-burst read results; a read burst fetches its first byte in S_LOOKUP
//   and loads it in S_BURST, then one byte per cycle while not stalled.
// One request at a time; the next is taken the cycle after its last load.
// Reset clears the pipe flags and the output valid; pointer and byte RAMs
//   are not cleared (allocate zeroes a pipe's pointers).
module multi_pipe_ring_buffer_pool_unit import mprb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        req_type,
  input  logic [PIPE_W-1:0] pipe_index,
  input  logic [7:0]        data_byte,
  input  logic [CNT_W-1:0]  byte_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic [PIPE_W-1:0] alloc_index,
  output logic [7:0]        read_byte,
  output logic              byte_valid,
  output logic              last,
  output logic [PTR_W-1:0]  fill_level
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);

  state_t state, state_next;

  // captured request
  logic [2:0]        req_q;
  logic [PIPE_W-1:0] pipe_q;
  logic [7:0]        data_q;
  logic [CNT_W-1:0]  count_q;

  // burst working registers
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [PTR_W-1:0] fill, fill_next;
  logic [CNT_W-1:0] remain, remain_next;

  // per-pipe flags
  logic [NUM_PIPES-1:0] in_use, in_use_next;
  logic [NUM_PIPES-1:0] rd_open, rd_open_next;
  logic [NUM_PIPES-1:0] wr_open, wr_open_next;

  // pointer RAM ports
  logic                 ptr_we;
  logic [PIPE_W-1:0]    ptr_waddr;
  logic [2*PTR_W-1:0]   ptr_wdata;
  logic [2*PTR_W-1:0]   ptr_rdata;

  // byte store ports
  logic                 st_we;
  logic [ADDR_W-1:0]    st_waddr;
  logic                 st_re;
  logic [ADDR_W-1:0]    st_raddr;
  logic [7:0]           st_rdata;

  // output load
  logic              out_free;
  logic              out_load;
  logic [2:0]        o_status;
  logic [PIPE_W-1:0] o_alloc;
  logic [7:0]        o_byte;
  logic              o_bvalid;
  logic              o_last;
  logic [PTR_W-1:0]  o_fill;

  // lookup helpers
  logic [PTR_W-1:0]  rd_head, rd_tail, level;
  logic              free_found;
  logic [PIPE_W-1:0] free_idx;
  logic [CNT_W-1:0]  cnt_sat;
  logic [CNT_W-1:0]  burst_n;
  logic              req_known;
  logic [PTR_W-1:0]  tail_inc;

  logic in_accept;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  mprb_ram #(.WIDTH(2*PTR_W), .DEPTH(NUM_PIPES)) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (ptr_waddr),
    .wdata (ptr_wdata),
    .re    (in_accept),
    .raddr (pipe_index),
    .rdata (ptr_rdata)
  );

  mprb_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (data_q),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // pointer fields and fill level of the addressed pipe
  assign rd_head   = ptr_rdata[2*PTR_W-1:PTR_W];
  assign rd_tail   = ptr_rdata[PTR_W-1:0];
  assign level     = rd_head - rd_tail;
  assign req_known = req_q inside {[REQ_WRITE:REQ_CLOSE_W]};
  assign tail_inc  = tail + 1'b1;

  // burst length: saturated count, bounded by bytes held
  assign cnt_sat = (count_q > CNT_W'(MAX_READ_BURST)) ? CNT_W'(MAX_READ_BURST) : count_q;
  assign burst_n = ({{(PTR_W-CNT_W){1'b0}}, cnt_sat} < level) ? cnt_sat : level[CNT_W-1:0];

  // lowest free pipe
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_PIPES - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_idx   = PIPE_W'(i);
      end
    end
  end

  // request sequencing
  always_comb begin
    state_next   = state;
    head_next    = head;
    tail_next    = tail;
    fill_next    = fill;
    remain_next  = remain;
    in_use_next  = in_use;
    rd_open_next = rd_open;
    wr_open_next = wr_open;
    ptr_we       = 1'b0;
    ptr_waddr    = pipe_q;
    ptr_wdata    = {head, tail};
    st_we        = 1'b0;
    st_waddr     = {pipe_q, rd_head};
    st_re        = 1'b0;
    st_raddr     = {pipe_q, rd_tail};
    out_load     = 1'b0;
    o_status     = STS_OK;
    o_alloc      = '0;
    o_byte       = '0;
    o_bvalid     = 1'b0;
    o_last       = 1'b1;
    o_fill       = '0;

    case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = S_LOOKUP;
        end
      end

      S_LOOKUP: begin
        if (out_free) begin
          state_next = S_IDLE;
          out_load   = 1'b1;
          if (req_q == REQ_ALLOC) begin
            if (free_found) begin
              in_use_next[free_idx]  = 1'b1;
              rd_open_next[free_idx] = 1'b1;
              wr_open_next[free_idx] = 1'b1;
              ptr_we    = 1'b1;
              ptr_waddr = free_idx;
              ptr_wdata = '0;
              o_alloc   = free_idx;
            end else begin
              o_status = STS_NOFREE;
            end
          end else if (!req_known || !in_use[pipe_q]) begin
            o_status = STS_BAD;
          end else if (req_q == REQ_WRITE) begin
            o_fill = level;
            if (!rd_open[pipe_q]) begin
              o_status = STS_BROKEN;
            end else if (&level) begin
              o_status = STS_FULL;
            end else begin
              st_we     = 1'b1;
              ptr_we    = 1'b1;
              ptr_wdata = {rd_head + 1'b1, rd_tail};
              o_fill    = level + 1'b1;
            end
          end else if (req_q == REQ_READ) begin
            if (count_q == '0) begin
              o_fill = level;
            end else if (level == '0) begin
              o_status = wr_open[pipe_q] ? STS_EMPTY : STS_EOF;
            end else begin
              // start burst: fetch first byte
              out_load    = 1'b0;
              state_next  = S_BURST;
              head_next   = rd_head;
              tail_next   = rd_tail;
              fill_next   = level;
              remain_next = burst_n;
              st_re       = 1'b1;
            end
          end else begin
            // close one end, free the pipe once both are closed
            if (req_q == REQ_CLOSE_R) begin
              rd_open_next[pipe_q] = 1'b0;
              in_use_next[pipe_q]  = wr_open[pipe_q];
            end else begin
              wr_open_next[pipe_q] = 1'b0;
              in_use_next[pipe_q]  = rd_open[pipe_q];
            end
            o_fill = level;
          end
        end
      end

      S_BURST: begin
        if (out_free) begin
          out_load    = 1'b1;
          o_byte      = st_rdata;
          o_bvalid    = 1'b1;
          o_last      = (remain == CNT_W'(1));
          o_fill      = fill - 1'b1;
          fill_next   = fill - 1'b1;
          tail_next   = tail_inc;
          remain_next = remain - 1'b1;
          if (remain == CNT_W'(1)) begin
            state_next = S_IDLE;
            ptr_we     = 1'b1;
            ptr_wdata  = {head, tail_inc};
          end else begin
            st_re    = 1'b1;
            st_raddr = {pipe_q, tail_inc};
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_use    <= '0;
      rd_open   <= '0;
      wr_open   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_use    <= in_use_next;
      rd_open   <= rd_open_next;
      wr_open   <= wr_open_next;
      out_valid <= out_load || (out_valid && out_stall);
    end
  end

  // request capture and burst working registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_q   <= req_type;
      pipe_q  <= pipe_index;
      data_q  <= data_byte;
      count_q <= byte_count;
    end
    head   <= head_next;
    tail   <= tail_next;
    fill   <= fill_next;
    remain <= remain_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= o_status;
      alloc_index <= o_alloc;
      read_byte   <= o_byte;
      byte_valid  <= o_bvalid;
      last        <= o_last;
      fill_level  <= o_fill;
    end
  end

endmodule

// ----- hw/rtl/mprb_ram.sv -----
module mprb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/mprb_checker.sv -----
module mprb_checker import mprb_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [2:0]        status,
  input logic [PIPE_W-1:0] alloc_index,
  input logic [7:0]        read_byte,
  input logic              byte_valid,
  input logic              last
);

  // one request in flight: stall rises right after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a request is in flight");

  // only burst bytes may be non-final results
  a_nonlast_is_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> byte_valid && status == STS_OK)
    else $error("non-final result without a byte");

  // a result without a byte carries a zero byte
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> read_byte == 8'd0)
    else $error("read_byte set without byte_valid");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(read_byte)
      && $stable(alloc_index) && $stable(last))
    else $error("stalled result changed");

endmodule

bind multi_pipe_ring_buffer_pool_unit mprb_checker u_mprb_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .alloc_index (alloc_index),
  .read_byte   (read_byte),
  .byte_valid  (byte_valid),
  .last        (last)
);
